// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the terminal stream writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TSW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TSW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/tsw_pkg.sv
// Shared types and byte codes for the terminal stream writer.
package tsw_pkg;

    // Byte codes recognized in the shell stream
    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] BS_BYTE   = 8'h08;
    localparam logic [7:0] TAB_BYTE  = 8'h09;
    localparam logic [7:0] CSI_BYTE  = 8'h5B;
    localparam logic [7:0] FINAL_LO  = 8'h40;
    localparam logic [7:0] FINAL_HI  = 8'h7E;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;
    localparam logic [6:0] SPACE_CHR = 7'h20;

    // A tab writes at most eight cells; this is the index of its final write
    localparam logic [2:0] TAB_LAST  = 3'd7;

    // Widths of the result fields on the output beat
    localparam int unsigned ROW_FW  = 11;
    localparam int unsigned COL_FW  = 9;
    localparam int unsigned CHR_FW  = 7;
    localparam int unsigned CCOL_FW = 10;
    localparam int unsigned CNT_FW  = 12;
    localparam int unsigned LEN_FW  = 10;
    localparam int unsigned TDATA_W = 72;
    localparam int unsigned TUSER_W = 2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
    } tsw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
    } tsw_stat_t;

    // One result beat
    typedef struct packed {
        logic                 write_valid;
        logic [ROW_FW-1:0]    write_row;
        logic [COL_FW-1:0]    write_col;
        logic [CHR_FW-1:0]    write_char;
        logic                 scrolled;
        logic [ROW_FW-1:0]    cur_row;
        logic [CCOL_FW-1:0]   cur_col;
        logic [CNT_FW-1:0]    rows_used;
        logic [LEN_FW-1:0]    longest_len;
        logic                 last;
    } tsw_res_t;

endpackage

// File: rtl/tsw_ctrl.sv
// Controller state machine: accepts a byte, then steps out its result beats.
module tsw_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tsw_pkg::tsw_cmd_t   cmd,
    input  tsw_pkg::tsw_stat_t  stat
);
    import tsw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Next state, commands and output-register occupancy
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: rtl/tsw_datapath.sv
// Datapath: escape tracking, cursor, row count, longest line and result register.
module tsw_datapath
#(
    parameter int unsigned MAX_LINES = 2048,
    parameter int unsigned MAX_COLS  = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  tsw_pkg::tsw_cmd_t   cmd,
    output tsw_pkg::tsw_stat_t  stat,
    output tsw_pkg::tsw_res_t   res
);
    import tsw_pkg::*;

    localparam int unsigned ROW_W = $clog2(MAX_LINES);
    localparam int unsigned CNT_W = $clog2(MAX_LINES + 1);
    localparam int unsigned COL_W = $clog2(MAX_COLS + 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_LINES - 1);
    localparam logic [COL_W-1:0] COL_LIM = COL_W'(MAX_COLS);

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_ESC    = 3'b010,
        PH_CSI    = 3'b100
    } phase_t;

    logic [7:0]       byte_reg;
    logic [2:0]       tab_cnt_reg, tab_cnt_next;
    phase_t           phase_reg, phase_next;
    logic [ROW_W-1:0] row_reg, row_next, row_adv;
    logic [COL_W-1:0] col_reg, col_next, put_col, col_plus;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_adv;
    logic [COL_W-1:0] longest_reg, longest_next;
    tsw_res_t         res_reg, res_next;

    logic             is_tab, do_put, do_lf, wrap, at_bottom, scrolled, last;
    logic [31:0]      wrow_w, wcol_w, crow_w, ccol_w, cnt_w, len_w;

    // Shared advance-row logic: clamp at the bottom row and scroll there
    assign at_bottom = (row_reg == ROW_MAX);
    assign row_adv   = at_bottom ? row_reg : row_reg + 1'b1;
    assign cnt_adv   = (cnt_reg > CNT_W'(row_adv) + 1'b1) ? cnt_reg
                                                           : CNT_W'(row_adv) + 1'b1;

    // Cell write position, wrapping at the right edge
    assign wrap     = (col_reg >= COL_LIM);
    assign put_col  = wrap ? '0 : col_reg;
    assign col_plus = put_col + 1'b1;

    // Decode the byte against the escape phase
    always_comb
    begin
        phase_next = PH_NORMAL;
        is_tab     = 1'b0;
        do_put     = 1'b0;
        do_lf      = 1'b0;
        col_next   = col_reg;
        unique case (phase_reg)
            PH_ESC:
            begin
                phase_next = (byte_reg == CSI_BYTE) ? PH_CSI : PH_NORMAL;
            end
            PH_CSI:
            begin
                phase_next = (byte_reg >= FINAL_LO && byte_reg <= FINAL_HI) ? PH_NORMAL
                                                                             : PH_CSI;
            end
            default:
            begin
                unique case (byte_reg) inside
                    ESC_BYTE: phase_next = PH_ESC;
                    CR_BYTE:  col_next = '0;
                    LF_BYTE:
                    begin
                        col_next = '0;
                        do_lf    = 1'b1;
                    end
                    BS_BYTE:
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                        end
                    end
                    TAB_BYTE:
                    begin
                        is_tab   = 1'b1;
                        do_put   = 1'b1;
                        col_next = col_plus;
                    end
                    [PRINT_LO:PRINT_HI]:
                    begin
                        do_put   = 1'b1;
                        col_next = col_plus;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // Row, row count and longest line after this step
    assign scrolled     = (do_lf || (do_put && wrap)) && at_bottom;
    assign row_next     = (do_lf || (do_put && wrap)) ? row_adv : row_reg;
    assign cnt_next     = (do_lf || (do_put && wrap)) ? cnt_adv : cnt_reg;
    assign longest_next = (do_put && col_plus > longest_reg) ? col_plus : longest_reg;

    // A tab stops at a multiple of eight or after its eighth write
    assign last = !is_tab || (col_plus[2:0] == 3'd0) || (tab_cnt_reg == TAB_LAST);
    assign tab_cnt_next = cmd.load ? 3'd0 : tab_cnt_reg + 3'd1;

    // Assemble the result beat with the field widths of the port
    always_comb
    begin
        wrow_w = 32'(row_next);
        wcol_w = 32'(put_col);
        crow_w = 32'(row_next);
        ccol_w = 32'(col_next);
        cnt_w  = 32'(cnt_next);
        len_w  = 32'(longest_next);
        res_next             = '0;
        res_next.write_valid = do_put;
        if (do_put)
        begin
            res_next.write_row  = wrow_w[ROW_FW-1:0];
            res_next.write_col  = wcol_w[COL_FW-1:0];
            res_next.write_char = is_tab ? SPACE_CHR : byte_reg[6:0];
        end
        res_next.scrolled    = scrolled;
        res_next.cur_row     = crow_w[ROW_FW-1:0];
        res_next.cur_col     = ccol_w[CCOL_FW-1:0];
        res_next.rows_used   = cnt_w[CNT_FW-1:0];
        res_next.longest_len = len_w[LEN_FW-1:0];
        res_next.last        = last;
    end

    // Terminal state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_NORMAL;
            row_reg     <= '0;
            col_reg     <= '0;
            cnt_reg     <= CNT_W'(1);
            longest_reg <= '0;
            tab_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load || cmd.step)
            begin
                tab_cnt_reg <= tab_cnt_next;
            end
            if (cmd.step)
            begin
                // A tab keeps the normal phase until its last write
                phase_reg   <= (do_put && !last) ? phase_reg : phase_next;
                row_reg     <= row_next;
                col_reg     <= col_next;
                cnt_reg     <= cnt_next;
                longest_reg <= longest_next;
            end
        end
    end

    // Byte and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.step)
        begin
            res_reg <= res_next;
        end
    end

    assign stat.last = last;
    assign res       = res_reg;

endmodule

// File: rtl/terminal_text_stream_writer_core.sv
// Top level of the terminal stream writer: byte stream in, cell-write beats out.
//
//  Channel | Dir | Handshake               | Payload
//  s_axis  | in  | s_axis_tvalid/tready    | tdata[7:0] in_byte
//  m_axis  | out | m_axis_tvalid/tready    | tdata (cell write and cursor), tuser, tlast
//
// A byte is accepted first, then the controller steps the datapath once per
// result beat: one beat for most bytes, up to eight for a tab that writes eight
// cells. A step waits while the output register holds a beat not yet taken.
// Reset (rst_n low, asynchronous) homes the cursor, sets one row in use and
// clears the escape phase. A stalled output holds its beat; the next byte
// is accepted while the last beat of the previous one still waits.
`include "assert_macros.svh"

module terminal_text_stream_writer_core
#(
    parameter int unsigned MAX_LINES = 2048,
    parameter int unsigned MAX_COLS  = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] write_row, [19:11] write_col, [26:20] write_char, [37:27] cur_row,
    // [47:38] cur_col, [59:48] rows_used, [69:60] longest_len, [71:70] zero
    output logic [tsw_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [tsw_pkg::TUSER_W-1:0] m_axis_tuser,  // [0] write_valid, [1] scrolled
    output logic        m_axis_tlast    // last beat for this byte
);
    import tsw_pkg::*;

    tsw_cmd_t  cmd;
    tsw_stat_t stat;
    tsw_res_t  res;

    tsw_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tsw_datapath #(
        .MAX_LINES (MAX_LINES),
        .MAX_COLS  (MAX_COLS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (s_axis_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .res     (res)
    );

    // Pack the result beat
    assign m_axis_tdata = {2'b00, res.longest_len, res.rows_used, res.cur_col,
                           res.cur_row, res.write_char, res.write_col, res.write_row};
    assign m_axis_tuser = {res.scrolled, res.write_valid};
    assign m_axis_tlast = res.last;

    // One byte at a time: no accept in the cycle after an accept
    `TSW_ASSERT_NXT(a_one_byte, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A beat without a cell write carries zero cell fields
    `TSW_ASSERT_IMP(a_nowrite_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[26:0] == 27'd0)
    // After a cell write the cursor sits one column to its right
    `TSW_ASSERT_IMP(a_write_advances, m_axis_tvalid && m_axis_tuser[0],
                    m_axis_tdata[46:38] == m_axis_tdata[19:11] + 9'd1)

endmodule
